// File: design/ioeu_pkg.sv
// ----------------------------------------------------------------------------
// ioeu_pkg
// Shared opcodes, widths and float constants of the op execute unit.
// ----------------------------------------------------------------------------
package ioeu_pkg;

   localparam int OP_W   = 5;
   localparam int WORD_W = 32;

   typedef enum logic [OP_W-1:0] {
      OP_MOV32   = 5'd0,
      OP_MOV64   = 5'd1,
      OP_ADD     = 5'd2,
      OP_SUB     = 5'd3,
      OP_AND     = 5'd4,
      OP_OR      = 5'd5,
      OP_XOR     = 5'd6,
      OP_NOT     = 5'd7,
      OP_NEG     = 5'd8,
      OP_SHL     = 5'd9,
      OP_SHR     = 5'd10,
      OP_SAR     = 5'd11,
      OP_TEST    = 5'd12,
      OP_SETEQ   = 5'd13,
      OP_SETGE   = 5'd14,
      OP_SETGT   = 5'd15,
      OP_SETAE   = 5'd16,
      OP_SETAB   = 5'd17,
      OP_EXT_S8  = 5'd18,
      OP_EXT_S16 = 5'd19,
      OP_FADD    = 5'd20,
      OP_FSUB    = 5'd21,
      OP_FMUL    = 5'd22,
      OP_FDIV    = 5'd23,
      OP_FABS    = 5'd24,
      OP_FNEG    = 5'd25,
      OP_JDYN    = 5'd26,
      OP_JCOND   = 5'd27,
      OP_IFB     = 5'd28
   } op_code_type;

   // single float layout and internal formats
   localparam int EXP_W   = 11;
   localparam int MANT_W  = 24;
   localparam int SIG_W   = 27;
   localparam int NORM_W  = 28;
   localparam int PROD_W  = 48;
   localparam int REM_W   = 25;

   localparam logic signed [EXP_W-1:0] EXP_BIAS = 11'sd127;
   localparam logic signed [EXP_W-1:0] EXP_MIN  = -11'sd126;
   localparam logic signed [EXP_W-1:0] EXP_FULL = 11'sd255;

   localparam logic [WORD_W-1:0] NAN_BITS = 32'h7FC0_0000;
   localparam logic [WORD_W-2:0] INF_MAG  = 31'h7F80_0000;
   localparam logic [WORD_W-1:0] SIGN_BIT = 32'h8000_0000;

   // unpack and align stages, one quotient bit per stage, then normalize and two rounding stages
   localparam int DIV_ITERS = 27;
   localparam int FP_STAGES = DIV_ITERS + 5;

endpackage

// File: design/ioeu_if.sv
// ----------------------------------------------------------------------------
// ioeu_if
// Request and response channels of the op execute unit.
// ----------------------------------------------------------------------------
interface ioeu_req_if import ioeu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   req_type;
   logic [WORD_W-1:0] operand_a;
   logic [WORD_W-1:0] operand_b;
   logic [WORD_W-1:0] operand_c;

   modport source (output valid, req_type, operand_a, operand_b, operand_c, input ready);
   modport sink (input valid, req_type, operand_a, operand_b, operand_c, output ready);
endinterface

interface ioeu_rsp_if import ioeu_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] result_low;
   logic [WORD_W-1:0] result_high;
   logic [1:0]        dest_writes;
   logic              block_exit;
   logic [WORD_W-1:0] exit_target;
   logic              unsupported;

   modport source (output valid, result_low, result_high, dest_writes, block_exit,
                   exit_target, unsupported, input ready);
   modport sink (input valid, result_low, result_high, dest_writes, block_exit,
                 exit_target, unsupported, output ready);
endinterface

// File: design/ioeu_fp_pipe.sv
// ----------------------------------------------------------------------------
// ioeu_fp_pipe
// Pipelined single float add, sub, mul and div with round to nearest even.
// ----------------------------------------------------------------------------
module ioeu_fp_pipe import ioeu_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [OP_W-1:0]   op,
   input  logic [WORD_W-1:0] op_a,
   input  logic [WORD_W-1:0] op_b,
   output logic [WORD_W-1:0] result
);

   localparam int DIV_NORM = DIV_ITERS + 2;
   localparam int RND_A    = DIV_ITERS + 3;
   localparam int RND_B    = DIV_ITERS + 4;

   typedef enum logic [1:0] {FK_NONE, FK_ADD, FK_MUL, FK_DIV} fp_kind_type;

   typedef struct packed {
      fp_kind_type              kind;
      logic                     spec;
      logic [WORD_W-1:0]        spec_bits;
      logic                     sign;
      logic                     eff_sub;
      logic                     tiny;
      logic signed [EXP_W-1:0]  ea;
      logic signed [EXP_W-1:0]  eb;
      logic [MANT_W-1:0]        ma;
      logic [MANT_W-1:0]        mb;
      logic [REM_W-1:0]         rem;
      logic [PROD_W-1:0]        wide;
   } fp_work_type;

   fp_work_type st_ff [FP_STAGES];
   fp_work_type st_in [FP_STAGES];

   // right shift keeping an or of the lost bits in the lsb
   function automatic logic [SIG_W-1:0] shr_sticky(input logic [SIG_W-1:0] x,
                                                   input logic [EXP_W-1:0] d);
      logic [SIG_W-1:0] mask;
      logic [SIG_W-1:0] r;
      mask = '0;
      if (d >= EXP_W'(SIG_W)) begin
         r = {{(SIG_W-1){1'b0}}, |x};
      end else begin
         mask = (SIG_W'(1) << d[4:0]) - SIG_W'(1);
         r = (x >> d[4:0]) | {{(SIG_W-1){1'b0}}, |(x & mask)};
      end
      return r;
   endfunction

   // leading one to the top in five steps, returns {count, shifted}
   function automatic logic [NORM_W+4:0] norm28(input logic [NORM_W-1:0] x);
      logic [NORM_W-1:0] v;
      logic [4:0]        n;
      v = x;
      n = '0;
      if (v[27:12] == '0) begin v = v << 16; n = n + 5'd16; end
      if (v[27:20] == '0) begin v = v << 8;  n = n + 5'd8;  end
      if (v[27:24] == '0) begin v = v << 4;  n = n + 5'd4;  end
      if (v[27:26] == '0) begin v = v << 2;  n = n + 5'd2;  end
      if (!v[27]) begin v = v << 1; n = n + 5'd1; end
      return {n, v};
   endfunction

   // one restoring quotient bit
   function automatic fp_work_type div_step(input fp_work_type w);
      fp_work_type      r;
      logic             q;
      logic [REM_W-1:0] diff;
      r = w;
      q = (w.rem >= {1'b0, w.mb});
      diff = q ? (w.rem - {1'b0, w.mb}) : w.rem;
      r.rem = {diff[REM_W-2:0], 1'b0};
      r.wide = {w.wide[PROD_W-2:0], q};
      return r;
   endfunction

   // ---------------- stage 0: unpack, specials, operand order ----------------
   logic                    sa, sb, sx;
   logic [7:0]              xa, xb;
   logic                    nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, swap;
   logic signed [EXP_W-1:0] ua, ub;
   logic [MANT_W-1:0]       ma0, mb0;
   fp_work_type             s0;

   assign xa     = op_a[30:23];
   assign xb     = op_b[30:23];
   assign sa     = op_a[31];
   assign sb     = op_b[31] ^ (op == OP_FSUB);
   assign sx     = sa ^ op_b[31];
   assign nan_a  = (&xa) && (|op_a[22:0]);
   assign nan_b  = (&xb) && (|op_b[22:0]);
   assign inf_a  = (&xa) && !(|op_a[22:0]);
   assign inf_b  = (&xb) && !(|op_b[22:0]);
   assign zero_a = (op_a[30:0] == '0);
   assign zero_b = (op_b[30:0] == '0);
   assign swap   = (op_b[30:0] > op_a[30:0]);
   assign ua     = $signed({3'b000, (xa == 8'd0) ? 8'd1 : xa}) - EXP_BIAS;
   assign ub     = $signed({3'b000, (xb == 8'd0) ? 8'd1 : xb}) - EXP_BIAS;
   assign ma0    = {xa != 8'd0, op_a[22:0]};
   assign mb0    = {xb != 8'd0, op_b[22:0]};

   always_comb begin
      s0 = '0;
      s0.sign = sx;
      s0.ea = ua;
      s0.eb = ub;
      s0.ma = ma0;
      s0.mb = mb0;
      case (op)
         OP_FADD, OP_FSUB: begin
            s0.kind = FK_ADD;
            s0.eff_sub = sa ^ sb;
            s0.sign = sa;
            if (swap) begin
               s0.sign = sb;
               s0.ea = ub;
               s0.eb = ua;
               s0.ma = mb0;
               s0.mb = ma0;
            end
            if (nan_a || nan_b || (inf_a && inf_b && (sa ^ sb))) begin
               s0.spec = 1'b1;
               s0.spec_bits = NAN_BITS;
            end else if (inf_a) begin
               s0.spec = 1'b1;
               s0.spec_bits = {sa, INF_MAG};
            end else if (inf_b) begin
               s0.spec = 1'b1;
               s0.spec_bits = {sb, INF_MAG};
            end
         end
         OP_FMUL: begin
            s0.kind = FK_MUL;
            s0.spec = 1'b1;
            if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) begin
               s0.spec_bits = NAN_BITS;
            end else if (inf_a || inf_b) begin
               s0.spec_bits = {sx, INF_MAG};
            end else if (zero_a || zero_b) begin
               s0.spec_bits = {sx, 31'd0};
            end else begin
               s0.spec = 1'b0;
            end
         end
         OP_FDIV: begin
            s0.kind = FK_DIV;
            s0.spec = 1'b1;
            if (nan_a || nan_b || (zero_a && zero_b) || (inf_a && inf_b)) begin
               s0.spec_bits = NAN_BITS;
            end else if (zero_b || inf_a) begin
               s0.spec_bits = {sx, INF_MAG};
            end else if (inf_b || zero_a) begin
               s0.spec_bits = {sx, 31'd0};
            end else begin
               s0.spec = 1'b0;
            end
         end
         default: begin
            s0.kind = FK_NONE;
         end
      endcase
      st_in[0] = s0;
   end

   // ---------------- stage 1: align addend, normalize mul/div inputs ----------------
   logic [NORM_W+4:0] s1_na, s1_nb;
   logic [SIG_W-1:0]  s1_al;
   fp_work_type       s1;

   assign s1_na = norm28({st_ff[0].ma, 4'b0000});
   assign s1_nb = norm28({st_ff[0].mb, 4'b0000});
   assign s1_al = shr_sticky({st_ff[0].mb, 3'b000}, st_ff[0].ea - st_ff[0].eb);

   always_comb begin
      s1 = st_ff[0];
      case (s1.kind)
         FK_ADD: begin
            s1.wide = {{(PROD_W-SIG_W){1'b0}}, s1_al};
         end
         FK_MUL, FK_DIV: begin
            s1.ma = s1_na[NORM_W-1:4];
            s1.mb = s1_nb[NORM_W-1:4];
            s1.ea = st_ff[0].ea - $signed({6'b0, s1_na[NORM_W+4:NORM_W]});
            s1.eb = st_ff[0].eb - $signed({6'b0, s1_nb[NORM_W+4:NORM_W]});
            s1.rem = {1'b0, s1_na[NORM_W-1:4]};
            s1.wide = '0;
         end
         default: begin
         end
      endcase
      st_in[1] = s1;
   end

   // ---------------- stage 2: add/sub, multiply, first quotient bit ----------------
   logic [NORM_W-1:0] s2_x, s2_y;
   fp_work_type       s2;

   assign s2_x = {1'b0, st_ff[1].ma, 3'b000};
   assign s2_y = {1'b0, st_ff[1].wide[SIG_W-1:0]};

   always_comb begin
      s2 = st_ff[1];
      case (s2.kind)
         FK_ADD: begin
            s2.wide = {{(PROD_W-NORM_W){1'b0}}, s2.eff_sub ? (s2_x - s2_y) : (s2_x + s2_y)};
         end
         FK_MUL: begin
            s2.wide = st_ff[1].ma * st_ff[1].mb;
         end
         FK_DIV: begin
            s2 = div_step(st_ff[1]);
         end
         default: begin
         end
      endcase
      st_in[2] = s2;
   end

   // ---------------- stage 3: normalize sum and product, second quotient bit ----------------
   logic [NORM_W+4:0] s3_n;
   logic [PROD_W-1:0] s3_p;
   fp_work_type       s3;

   assign s3_n = norm28(st_ff[2].wide[NORM_W-1:0]);
   assign s3_p = st_ff[2].wide;

   always_comb begin
      s3 = st_ff[2];
      case (s3.kind)
         FK_ADD: begin
            if (st_ff[2].wide[NORM_W-1:0] == '0) begin
               if (!s3.spec) begin
                  s3.spec = 1'b1;
                  s3.spec_bits = {st_ff[2].sign & !st_ff[2].eff_sub, 31'd0};
               end
            end else begin
               s3.ea = st_ff[2].ea + EXP_W'(1) - $signed({6'b0, s3_n[NORM_W+4:NORM_W]});
               s3.wide = {{(PROD_W-SIG_W){1'b0}},
                          s3_n[NORM_W-1:1] | {{(SIG_W-1){1'b0}}, s3_n[0]}};
            end
         end
         FK_MUL: begin
            if (s3_p[47]) begin
               s3.ea = st_ff[2].ea + st_ff[2].eb + EXP_W'(1);
               s3.wide = {{(PROD_W-SIG_W){1'b0}},
                          s3_p[47:21] | {{(SIG_W-1){1'b0}}, |s3_p[20:0]}};
            end else begin
               s3.ea = st_ff[2].ea + st_ff[2].eb;
               s3.wide = {{(PROD_W-SIG_W){1'b0}},
                          s3_p[46:20] | {{(SIG_W-1){1'b0}}, |s3_p[19:0]}};
            end
         end
         FK_DIV: begin
            s3 = div_step(st_ff[2]);
         end
         default: begin
         end
      endcase
      st_in[3] = s3;
   end

   // ---------------- remaining quotient bits ----------------
   for (genvar k = 4; k < DIV_NORM; k++) begin : g_div
      always_comb begin
         if (st_ff[k-1].kind == FK_DIV) begin
            st_in[k] = div_step(st_ff[k-1]);
         end else begin
            st_in[k] = st_ff[k-1];
         end
      end
   end

   // ---------------- quotient to leading-one form ----------------
   logic [SIG_W-1:0] dq;
   logic             dst;
   fp_work_type      sdn;

   assign dq  = st_ff[DIV_NORM-1].wide[SIG_W-1:0];
   assign dst = |st_ff[DIV_NORM-1].rem;

   always_comb begin
      sdn = st_ff[DIV_NORM-1];
      if (sdn.kind == FK_DIV) begin
         if (dq[SIG_W-1]) begin
            sdn.ea = st_ff[DIV_NORM-1].ea - st_ff[DIV_NORM-1].eb;
            sdn.wide = {{(PROD_W-SIG_W){1'b0}}, dq | {{(SIG_W-1){1'b0}}, dst}};
         end else begin
            sdn.ea = st_ff[DIV_NORM-1].ea - st_ff[DIV_NORM-1].eb - EXP_W'(1);
            sdn.wide = {{(PROD_W-SIG_W){1'b0}}, dq[SIG_W-2:0], dst};
         end
      end
      st_in[DIV_NORM] = sdn;
   end

   // ---------------- rounding: denormalize tiny results ----------------
   logic [SIG_W-1:0] ra_sh;
   fp_work_type      sra;

   assign ra_sh = shr_sticky(st_ff[RND_A-1].wide[SIG_W-1:0], EXP_MIN - st_ff[RND_A-1].ea);

   always_comb begin
      sra = st_ff[RND_A-1];
      sra.tiny = 1'b0;
      if (sra.kind != FK_NONE && !sra.spec && sra.ea < EXP_MIN) begin
         sra.tiny = 1'b1;
         sra.ea = EXP_MIN;
         sra.wide = {{(PROD_W-SIG_W){1'b0}}, ra_sh};
      end
      st_in[RND_A] = sra;
   end

   // ---------------- rounding: nearest even and pack ----------------
   logic [MANT_W-1:0]       rb_mant;
   logic                    rb_inc;
   logic [MANT_W:0]         rb_m;
   logic signed [EXP_W-1:0] rb_be;
   logic [22:0]             rb_frac;
   fp_work_type             srb;

   assign rb_mant = st_ff[RND_B-1].wide[SIG_W-1:3];
   assign rb_inc  = st_ff[RND_B-1].wide[2]
                  & ((|st_ff[RND_B-1].wide[1:0]) | st_ff[RND_B-1].wide[3]);
   assign rb_m    = {1'b0, rb_mant} + {{MANT_W{1'b0}}, rb_inc};
   assign rb_frac = rb_m[MANT_W] ? rb_m[23:1] : rb_m[22:0];

   always_comb begin
      if (st_ff[RND_B-1].tiny) begin
         rb_be = rb_m[23] ? EXP_W'(1) : EXP_W'(0);
      end else begin
         rb_be = st_ff[RND_B-1].ea + EXP_BIAS + {{(EXP_W-1){1'b0}}, rb_m[MANT_W]};
      end
   end

   always_comb begin
      srb = st_ff[RND_B-1];
      if (srb.spec) begin
         srb.wide = {{(PROD_W-WORD_W){1'b0}}, srb.spec_bits};
      end else if (rb_be >= EXP_FULL) begin
         srb.wide = {{(PROD_W-WORD_W){1'b0}}, srb.sign, INF_MAG};
      end else begin
         srb.wide = {{(PROD_W-WORD_W){1'b0}}, srb.sign, rb_be[7:0], rb_frac};
      end
      st_in[RND_B] = srb;
   end

   for (genvar k = 0; k < FP_STAGES; k++) begin : g_reg
      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign result = st_ff[FP_STAGES-1].wide[WORD_W-1:0];

endmodule

// File: design/ir_op_execute_unit.sv
// ----------------------------------------------------------------------------
// ir_op_execute_unit
// Executes one intermediate-code op per beat: integer ALU, compares, sign
// extension, IEEE single add/sub/mul/div, sign ops and branch exits. The unit
// takes a new beat every cycle unless the pipe is held, and every op takes the
// same path: the result beat is offered at the end of 32 register stages set
// by the float divider, which resolves one quotient bit per pipeline stage (27
// stages) between unpack, alignment and rounding stages.
// The whole pipe advances together: it holds only while a finished result
// waits and the response side is not ready, and the request side is held off
// for that whole time, even when the pipe has gaps in it.
// ----------------------------------------------------------------------------
module ir_op_execute_unit import ioeu_pkg::*; (
   input logic        clock,
   input logic        reset,
   ioeu_req_if.sink   req_chan,
   ioeu_rsp_if.source rsp_chan
);

   typedef struct packed {
      logic              fp;
      logic [WORD_W-1:0] lo;
      logic [WORD_W-1:0] hi;
      logic [1:0]        writes;
      logic              exitb;
      logic [WORD_W-1:0] target;
      logic              unsup;
   } int_res_type;

   logic [FP_STAGES-1:0] vld_ff;
   int_res_type          res_ff [FP_STAGES];
   int_res_type          res_in;
   logic                 en;
   logic [WORD_W-1:0]    fp_result;
   logic [WORD_W-1:0]    a, b, c;
   logic                 big_shift;

   assign en = !vld_ff[FP_STAGES-1] || rsp_chan.ready;
   assign req_chan.ready = en;

   assign a = req_chan.operand_a;
   assign b = req_chan.operand_b;
   assign c = req_chan.operand_c;
   assign big_shift = |b[WORD_W-1:5];

   always_comb begin
      res_in = '0;
      res_in.writes = 2'd1;
      case (req_chan.req_type)
         OP_MOV32:   res_in.lo = a;
         OP_MOV64: begin
            res_in.lo = a;
            res_in.hi = b;
            res_in.writes = 2'd2;
         end
         OP_ADD:     res_in.lo = a + b;
         OP_SUB:     res_in.lo = a - b;
         OP_AND:     res_in.lo = a & b;
         OP_OR:      res_in.lo = a | b;
         OP_XOR:     res_in.lo = a ^ b;
         OP_NOT:     res_in.lo = ~a;
         OP_NEG:     res_in.lo = '0 - a;
         OP_SHL:     res_in.lo = big_shift ? '0 : (a << b[4:0]);
         OP_SHR:     res_in.lo = big_shift ? '0 : (a >> b[4:0]);
         OP_SAR: begin
            res_in.lo = big_shift ? {WORD_W{a[WORD_W-1]}} : WORD_W'($signed(a) >>> b[4:0]);
         end
         OP_TEST:    res_in.lo = {31'd0, (a & b) == '0};
         OP_SETEQ:   res_in.lo = {31'd0, a == b};
         OP_SETGE:   res_in.lo = {31'd0, $signed(a) >= $signed(b)};
         OP_SETGT:   res_in.lo = {31'd0, $signed(a) > $signed(b)};
         OP_SETAE:   res_in.lo = {31'd0, a >= b};
         OP_SETAB:   res_in.lo = {31'd0, a > b};
         OP_EXT_S8:  res_in.lo = {{24{a[7]}}, a[7:0]};
         OP_EXT_S16: res_in.lo = {{16{a[15]}}, a[15:0]};
         OP_FADD, OP_FSUB, OP_FMUL, OP_FDIV: res_in.fp = 1'b1;
         OP_FABS:    res_in.lo = a & ~SIGN_BIT;
         OP_FNEG:    res_in.lo = a ^ SIGN_BIT;
         OP_JDYN, OP_IFB: begin
            res_in.writes = 2'd0;
            res_in.exitb = 1'b1;
            res_in.target = a;
         end
         OP_JCOND: begin
            res_in.writes = 2'd0;
            res_in.exitb = 1'b1;
            res_in.target = (b != '0) ? a : c;
         end
         default: begin
            res_in.writes = 2'd0;
            res_in.unsup = 1'b1;
         end
      endcase
   end

   ioeu_fp_pipe u_fp (
      .clock  (clock),
      .en     (en),
      .op     (req_chan.req_type),
      .op_a   (a),
      .op_b   (b),
      .result (fp_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[FP_STAGES-2:0], req_chan.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff[0] <= res_in;
      end
   end

   for (genvar k = 1; k < FP_STAGES; k++) begin : g_line
      always_ff @(posedge clock) begin
         if (en) begin
            res_ff[k] <= res_ff[k-1];
         end
      end
   end

   assign rsp_chan.valid       = vld_ff[FP_STAGES-1];
   assign rsp_chan.result_low  = res_ff[FP_STAGES-1].fp ? fp_result : res_ff[FP_STAGES-1].lo;
   assign rsp_chan.result_high = res_ff[FP_STAGES-1].hi;
   assign rsp_chan.dest_writes = res_ff[FP_STAGES-1].writes;
   assign rsp_chan.block_exit  = res_ff[FP_STAGES-1].exitb;
   assign rsp_chan.exit_target = res_ff[FP_STAGES-1].target;
   assign rsp_chan.unsupported = res_ff[FP_STAGES-1].unsup;

   a_unsup_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.unsupported |->
         rsp_chan.dest_writes == 2'd0 && !rsp_chan.block_exit && rsp_chan.result_low == '0)
      else $error("unsupported op wrote a result");

   a_high_only_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.dest_writes != 2'd2 |-> rsp_chan.result_high == '0)
      else $error("high word set without a pair move");

   a_exit_target: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.block_exit |->
         rsp_chan.exit_target == '0 && rsp_chan.dest_writes != 2'd0 || rsp_chan.unsupported)
      else $error("exit target or write count inconsistent with branch flag");

endmodule
